[hw/rtl/cssc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cssc_pkg - colour sensor scan classifier package
// Widths, register and colour codes, microcode format and the control store.
// ----------------------------------------------------------------------------
package cssc_pkg;

	// Widths
	localparam int CNT_W      = 24;
	localparam int WGT_W      = 8;
	localparam int FRAC_W     = 8;
	localparam int PROD_W     = CNT_W + WGT_W;
	localparam int DVD_W      = PROD_W + FRAC_W;
	localparam int RATIO_W    = DVD_W + 1;
	localparam int ITER_W     = $clog2(DVD_W + 1);
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = CNT_W;
	localparam int COLOR_W    = 3;
	localparam int FLT_W      = 2;
	localparam int STEP_W     = 4;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// Register reset values
	localparam logic [CNT_W-1:0] RST_BLACK   = CNT_W'(10);
	localparam logic [CNT_W-1:0] RST_TIMEOUT = CNT_W'(1000000);
	localparam logic [WGT_W-1:0] RST_RED_W   = WGT_W'(100);
	localparam logic [WGT_W-1:0] RST_GREEN_W = WGT_W'(125);
	localparam logic [WGT_W-1:0] RST_BLUE_W  = WGT_W'(79);

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BLACK   = 3'd0,
		REG_TIMEOUT = 3'd1,
		REG_RED_W   = 3'd2,
		REG_GREEN_W = 3'd3,
		REG_BLUE_W  = 3'd4
	} cfg_reg_t;

	// Colour codes
	localparam logic [COLOR_W-1:0] COL_BLACK = 3'd0;
	localparam logic [COLOR_W-1:0] COL_RED   = 3'd1;
	localparam logic [COLOR_W-1:0] COL_GREEN = 3'd2;
	localparam logic [COLOR_W-1:0] COL_BLUE  = 3'd3;
	localparam logic [COLOR_W-1:0] COL_WHITE = 3'd4;

	// Filter indexes
	localparam logic [FLT_W-1:0] FLT_CLEAR = 2'd0;
	localparam logic [FLT_W-1:0] FLT_RED   = 2'd1;
	localparam logic [FLT_W-1:0] FLT_GREEN = 2'd2;
	localparam logic [FLT_W-1:0] FLT_BLUE  = 2'd3;

	// Scan phase
	typedef enum logic [3:0] {
		PH_IDLE      = 4'b0001,
		PH_WAIT_LOW  = 4'b0010,
		PH_WAIT_HIGH = 4'b0100,
		PH_MEASURE   = 4'b1000
	} phase_t;

	// Micro-operations
	typedef enum logic [2:0] {
		OP_NOP      = 3'd0,
		OP_ACCEPT   = 3'd1,
		OP_TICK     = 3'd2,
		OP_LOAD     = 3'd3,
		OP_DIV      = 3'd4,
		OP_STORE    = 3'd5,
		OP_CLASSIFY = 3'd6,
		OP_EMIT     = 3'd7
	} op_t;

	// Jump conditions
	typedef enum logic [2:0] {
		C_NEXT     = 3'd0,
		C_ALWAYS   = 3'd1,
		C_NO_ITEM  = 3'd2,
		C_NOT_END  = 3'd3,
		C_IS_BLACK = 3'd4,
		C_DIV_RUN  = 3'd5,
		C_OUT_BUSY = 3'd6
	} cond_t;

	typedef struct packed {
		op_t               op;
		logic [FLT_W-1:0]  sel;
		cond_t             cond;
		logic [STEP_W-1:0] target;
	} uword_t;

	// Step addresses
	localparam logic [STEP_W-1:0] STEP_ACCEPT = 4'd0;
	localparam logic [STEP_W-1:0] STEP_TICK   = 4'd1;
	localparam logic [STEP_W-1:0] STEP_TEST   = 4'd2;
	localparam logic [STEP_W-1:0] STEP_LD_R   = 4'd3;
	localparam logic [STEP_W-1:0] STEP_DV_R   = 4'd4;
	localparam logic [STEP_W-1:0] STEP_ST_R   = 4'd5;
	localparam logic [STEP_W-1:0] STEP_LD_G   = 4'd6;
	localparam logic [STEP_W-1:0] STEP_DV_G   = 4'd7;
	localparam logic [STEP_W-1:0] STEP_ST_G   = 4'd8;
	localparam logic [STEP_W-1:0] STEP_LD_B   = 4'd9;
	localparam logic [STEP_W-1:0] STEP_DV_B   = 4'd10;
	localparam logic [STEP_W-1:0] STEP_ST_B   = 4'd11;
	localparam logic [STEP_W-1:0] STEP_CLASS  = 4'd12;
	localparam logic [STEP_W-1:0] STEP_EMIT   = 4'd15;

	// Control store: the emit step is last so the next step wraps to accept
	function automatic uword_t ucode(input logic [STEP_W-1:0] step);
		uword_t w;
		w = '{op: OP_NOP, sel: FLT_CLEAR, cond: C_ALWAYS, target: STEP_ACCEPT};
		unique case (step)
			STEP_ACCEPT: w = '{OP_ACCEPT,   FLT_CLEAR, C_NO_ITEM,  STEP_ACCEPT};
			STEP_TICK:   w = '{OP_TICK,     FLT_CLEAR, C_NOT_END,  STEP_EMIT};
			STEP_TEST:   w = '{OP_NOP,      FLT_CLEAR, C_IS_BLACK, STEP_EMIT};
			STEP_LD_R:   w = '{OP_LOAD,     FLT_RED,   C_NEXT,     STEP_ACCEPT};
			STEP_DV_R:   w = '{OP_DIV,      FLT_RED,   C_DIV_RUN,  STEP_DV_R};
			STEP_ST_R:   w = '{OP_STORE,    FLT_RED,   C_NEXT,     STEP_ACCEPT};
			STEP_LD_G:   w = '{OP_LOAD,     FLT_GREEN, C_NEXT,     STEP_ACCEPT};
			STEP_DV_G:   w = '{OP_DIV,      FLT_GREEN, C_DIV_RUN,  STEP_DV_G};
			STEP_ST_G:   w = '{OP_STORE,    FLT_GREEN, C_NEXT,     STEP_ACCEPT};
			STEP_LD_B:   w = '{OP_LOAD,     FLT_BLUE,  C_NEXT,     STEP_ACCEPT};
			STEP_DV_B:   w = '{OP_DIV,      FLT_BLUE,  C_DIV_RUN,  STEP_DV_B};
			STEP_ST_B:   w = '{OP_STORE,    FLT_BLUE,  C_NEXT,     STEP_ACCEPT};
			STEP_CLASS:  w = '{OP_CLASSIFY, FLT_CLEAR, C_ALWAYS,   STEP_EMIT};
			STEP_EMIT:   w = '{OP_EMIT,     FLT_CLEAR, C_OUT_BUSY, STEP_EMIT};
			default:     w = '{OP_NOP,      FLT_CLEAR, C_ALWAYS,   STEP_ACCEPT};
		endcase
		return w;
	endfunction

	// Divider request and response
	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             zero_div;
		logic [DVD_W-1:0] quotient;
	} div_rsp_t;

	// Result fields held until emitted
	typedef struct packed {
		logic               filter_s2;
		logic               filter_s3;
		logic               busy;
		logic               done;
		logic [COLOR_W-1:0] color;
		logic               timed_out;
	} result_t;

endpackage
`default_nettype wire

[hw/rtl/cssc_ifs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cssc_ifs - channel interfaces
// Tick input, result output and register write channels.
// ----------------------------------------------------------------------------
interface cssc_in_if;
	import cssc_pkg::*;
	logic valid;
	logic ready;
	logic command;
	logic sensor_level;
	modport source(output valid, command, sensor_level, input ready);
	modport sink(input valid, command, sensor_level, output ready);
endinterface

interface cssc_out_if;
	import cssc_pkg::*;
	logic               valid;
	logic               ready;
	logic               filter_s2;
	logic               filter_s3;
	logic               scale_enable;
	logic               led_enable;
	logic               busy_res;
	logic               done_res;
	logic [COLOR_W-1:0] color;
	logic               timed_out;
	modport source(output valid, filter_s2, filter_s3, scale_enable, led_enable,
		busy_res, done_res, color, timed_out, input ready);
	modport sink(input valid, filter_s2, filter_s3, scale_enable, led_enable,
		busy_res, done_res, color, timed_out, output ready);
endinterface

interface cssc_cfg_if;
	import cssc_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

[hw/rtl/cssc_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cssc_div - iterative ratio divider
// Restoring division, one quotient bit per cycle, flags a zero divisor.
// ----------------------------------------------------------------------------
module cssc_div (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire cssc_pkg::div_req_t req,
	output cssc_pkg::div_rsp_t     rsp
);
	import cssc_pkg::*;

	logic [ITER_W-1:0] cnt_q;
	logic [DVD_W-1:0]  quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  dvsr_q;
	logic              zero_q;
	logic [CNT_W:0]    trial;
	logic [CNT_W:0]    diff;
	logic              fits;

	// Trial subtract of the shifted remainder
	always_comb begin
		trial = {rem_q, quo_q[DVD_W-1]};
		diff  = trial - {1'b0, dvsr_q};
		fits  = trial >= {1'b0, dvsr_q};
	end

	// Count the iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= ITER_W'(DVD_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Shift in one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q  <= req.dividend;
			rem_q  <= '0;
			dvsr_q <= req.divisor;
			zero_q <= (req.divisor == '0);
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[DVD_W-2:0], fits};
			rem_q <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
		end
	end

	assign rsp.busy     = (cnt_q != '0);
	assign rsp.zero_div = zero_q;
	assign rsp.quotient = quo_q;

endmodule
`default_nettype wire

[hw/rtl/color_sensor_scan_classifier.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// color_sensor_scan_classifier - colour sensor scan sequencer and classifier
// Steps a light-to-frequency sensor through its four filters one tick at a
// time, measures one high pulse per filter and classifies the colour.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake    | payload
//  sample   | in  | valid/ready  | command, sensor_level
//  result   | out | valid/ready  | filter_s2, filter_s3, scale_enable,
//           |     |              | led_enable, busy_res, done_res, color,
//           |     |              | timed_out
//  cfg      | in  | valid/ready  | index, data (always ready)
//
//  A microcoded sequencer runs one short program per tick item.
//  Plain tick: accept, update, emit. Black at scan end: accept, update, test, emit.
//  Scan end otherwise: accept, update and test, then load, division and store for
//  each of the three ratios on the 40-step divider that they share, then classify and emit.
//  The next item is accepted while the previous result waits in the output
//  register; the emit step holds while that register is still full.
//  Reset clears the sequencer and the scan state and loads the registers with their reset values at once.
// ----------------------------------------------------------------------------
module color_sensor_scan_classifier (
	input  wire         clk,
	input  wire         arst_n,
	cssc_in_if.sink     sample,
	cssc_out_if.source  result,
	cssc_cfg_if.sink    cfg
);
	import cssc_pkg::*;

	// Sequencer
	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_d;
	uword_t            uw;
	logic              take;
	logic              in_acc;

	// Registers
	logic [CNT_W-1:0] black_q;
	logic [CNT_W-1:0] timeout_q;
	logic [WGT_W-1:0] red_wt_q;
	logic [WGT_W-1:0] green_wt_q;
	logic [WGT_W-1:0] blue_wt_q;

	// Scan state
	phase_t           phase_q;
	phase_t           ph_d;
	logic [FLT_W-1:0] filt_q;
	logic [FLT_W-1:0] filt_d;
	logic [CNT_W-1:0] tick_q;
	logic [CNT_W-1:0] tick_d;
	logic [CNT_W-1:0] tick_inc;
	logic [CNT_W-1:0] limit;
	logic [CNT_W-1:0] wcur_q;
	logic [CNT_W-1:0] wcur_d;
	logic             tmo_q;
	logic             tmo_d;
	logic             ended;
	logic             tk_done;
	logic [CNT_W-1:0] clear_w_q;
	logic [CNT_W-1:0] red_w_q;
	logic [CNT_W-1:0] green_w_q;
	logic [CNT_W-1:0] blue_w_q;
	logic             cmd_q;
	logic             level_q;

	// Ratios and classification
	logic [WGT_W-1:0]   wsel;
	logic [CNT_W-1:0]   dsel;
	logic [PROD_W-1:0]  prod;
	logic [RATIO_W-1:0] ratio_val;
	logic [RATIO_W-1:0] r_ratio_q;
	logic [RATIO_W-1:0] g_ratio_q;
	logic [RATIO_W-1:0] b_ratio_q;
	logic [COLOR_W-1:0] class_col;
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	// Result
	result_t pend_q;
	result_t out_q;
	logic    out_valid_q;
	logic    out_busy;

	assign uw     = ucode(step_q);
	assign in_acc = sample.valid && sample.ready;
	assign sample.ready = (uw.op == OP_ACCEPT);
	assign cfg.ready    = 1'b1;
	assign out_busy     = out_valid_q && !result.ready;

	// Evaluate the jump condition
	always_comb begin
		unique case (uw.cond)
			C_NEXT:     take = 1'b0;
			C_ALWAYS:   take = 1'b1;
			C_NO_ITEM:  take = !in_acc;
			C_NOT_END:  take = !tk_done;
			C_IS_BLACK: take = clear_w_q > black_q;
			C_DIV_RUN:  take = div_rsp.busy;
			C_OUT_BUSY: take = out_busy;
			default:    take = 1'b1;
		endcase
		step_d = take ? uw.target : step_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_ACCEPT;
		end else begin
			step_q <= step_d;
		end
	end

	// Latch the tick item
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q   <= sample.command;
			level_q <= sample.sensor_level;
		end
	end

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			black_q    <= RST_BLACK;
			timeout_q  <= RST_TIMEOUT;
			red_wt_q   <= RST_RED_W;
			green_wt_q <= RST_GREEN_W;
			blue_wt_q  <= RST_BLUE_W;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_BLACK:   black_q    <= cfg.data;
				REG_TIMEOUT: timeout_q  <= cfg.data;
				REG_RED_W:   red_wt_q   <= cfg.data[WGT_W-1:0];
				REG_GREEN_W: green_wt_q <= cfg.data[WGT_W-1:0];
				REG_BLUE_W:  blue_wt_q  <= cfg.data[WGT_W-1:0];
				default: ;
			endcase
		end
	end

	// Advance the scan by one tick
	always_comb begin
		ph_d     = phase_q;
		filt_d   = filt_q;
		tick_d   = tick_q;
		wcur_d   = wcur_q;
		tmo_d    = tmo_q;
		ended    = 1'b0;
		tk_done  = 1'b0;
		tick_inc = tick_q;
		limit    = (timeout_q == '0) ? CNT_W'(1) : timeout_q;
		if (phase_q == PH_IDLE) begin
			if (cmd_q) begin
				ph_d   = PH_WAIT_LOW;
				filt_d = FLT_CLEAR;
				tick_d = '0;
				tmo_d  = 1'b0;
			end
		end else begin
			unique case (phase_q)
				PH_WAIT_LOW: begin
					if (!level_q) ph_d = PH_WAIT_HIGH;
				end
				PH_WAIT_HIGH: begin
					if (level_q) begin
						wcur_d = CNT_W'(1);
						ph_d   = PH_MEASURE;
					end
				end
				PH_MEASURE: begin
					if (level_q) begin
						if (wcur_q != CNT_MAX) wcur_d = wcur_q + 1'b1;
					end else begin
						ended = 1'b1;
					end
				end
				default: ;
			endcase
			// Give up once the timeout is reached
			if (!ended) begin
				if (tick_q != CNT_MAX) tick_inc = tick_q + 1'b1;
				tick_d = tick_inc;
				if (tick_inc >= limit || tick_inc == CNT_MAX) begin
					wcur_d = '0;
					tmo_d  = 1'b1;
					ended  = 1'b1;
				end
			end
			// Move on to the next filter or end the scan
			if (ended) begin
				tick_d = '0;
				if (filt_q == FLT_BLUE) begin
					ph_d    = PH_IDLE;
					filt_d  = FLT_CLEAR;
					tk_done = 1'b1;
				end else begin
					filt_d = filt_q + 1'b1;
					ph_d   = PH_WAIT_LOW;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			filt_q    <= FLT_CLEAR;
			tick_q    <= '0;
			wcur_q    <= '0;
			tmo_q     <= 1'b0;
			clear_w_q <= '0;
			red_w_q   <= '0;
			green_w_q <= '0;
			blue_w_q  <= '0;
		end else if (uw.op == OP_TICK) begin
			phase_q <= ph_d;
			filt_q  <= filt_d;
			tick_q  <= tick_d;
			wcur_q  <= wcur_d;
			tmo_q   <= tmo_d;
			if (ended) begin
				unique case (filt_q)
					FLT_CLEAR: clear_w_q <= wcur_d;
					FLT_RED:   red_w_q   <= wcur_d;
					FLT_GREEN: green_w_q <= wcur_d;
					FLT_BLUE:  blue_w_q  <= wcur_d;
					default: ;
				endcase
			end
		end
	end

	// Select weight and width for the ratio in hand
	always_comb begin
		unique case (uw.sel)
			FLT_RED: begin
				wsel = red_wt_q;
				dsel = red_w_q;
			end
			FLT_GREEN: begin
				wsel = green_wt_q;
				dsel = green_w_q;
			end
			FLT_BLUE: begin
				wsel = blue_wt_q;
				dsel = blue_w_q;
			end
			default: begin
				wsel = '0;
				dsel = clear_w_q;
			end
		endcase
		prod = PROD_W'(clear_w_q) * PROD_W'(wsel);
	end

	assign div_req.start    = (uw.op == OP_LOAD);
	assign div_req.dividend = {prod, {FRAC_W{1'b0}}};
	assign div_req.divisor  = dsel;

	cssc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Saturate the ratio on a zero width
	assign ratio_val = div_rsp.zero_div ? {RATIO_W{1'b1}} : {1'b0, div_rsp.quotient};

	always_ff @(posedge clk) begin
		if (uw.op == OP_STORE) begin
			unique case (uw.sel)
				FLT_RED:   r_ratio_q <= ratio_val;
				FLT_GREEN: g_ratio_q <= ratio_val;
				FLT_BLUE:  b_ratio_q <= ratio_val;
				default: ;
			endcase
		end
	end

	// Pick the strictly largest ratio, white on a tie
	always_comb begin
		priority if (r_ratio_q > g_ratio_q && r_ratio_q > b_ratio_q) begin
			class_col = COL_RED;
		end else if (g_ratio_q > r_ratio_q && g_ratio_q > b_ratio_q) begin
			class_col = COL_GREEN;
		end else if (b_ratio_q > g_ratio_q && b_ratio_q > r_ratio_q) begin
			class_col = COL_BLUE;
		end else begin
			class_col = COL_WHITE;
		end
	end

	// Build the pending result
	always_ff @(posedge clk) begin
		if (uw.op == OP_TICK) begin
			pend_q.busy      <= (ph_d != PH_IDLE);
			pend_q.filter_s2 <= (ph_d != PH_IDLE) &&
				(filt_d == FLT_CLEAR || filt_d == FLT_GREEN);
			pend_q.filter_s3 <= (ph_d != PH_IDLE) &&
				(filt_d == FLT_GREEN || filt_d == FLT_BLUE);
			pend_q.done      <= tk_done;
			pend_q.color     <= COL_BLACK;
			pend_q.timed_out <= tmo_d;
		end else if (uw.op == OP_CLASSIFY) begin
			pend_q.color <= class_col;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (uw.op == OP_EMIT && !out_busy) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (uw.op == OP_EMIT && !out_busy) begin
			out_q <= pend_q;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.filter_s2    = out_q.filter_s2;
	assign result.filter_s3    = out_q.filter_s3;
	assign result.scale_enable = out_q.busy;
	assign result.led_enable   = out_q.busy;
	assign result.busy_res     = out_q.busy;
	assign result.done_res     = out_q.done;
	assign result.color        = out_q.color;
	assign result.timed_out    = out_q.timed_out;

`ifndef SYNTHESIS
	a_acc_then_tick: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> step_q == STEP_TICK)
		else $error("accepted item not followed by the update step");

	a_div_in_div_step: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.busy |-> uw.op == OP_DIV)
		else $error("divider running outside a divide step");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.done_res |-> !result.busy_res)
		else $error("scan end reported while still busy");

	a_color_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.done_res |-> result.color == COL_BLACK)
		else $error("colour reported without scan end");

	a_filter_idle: assert property (@(posedge clk) disable iff (!arst_n)
		filt_q != FLT_CLEAR |-> phase_q != PH_IDLE)
		else $error("filter index left set while idle");
`endif

endmodule
`default_nettype wire
